### sv/token_bucket_budget_pacer_unit_macros.svh
// Assertion macros shared by the pacer checker.
// No dependencies; included by files that carry assertions.
`ifndef TOKEN_BUCKET_BUDGET_PACER_UNIT_MACROS_SVH
`define TOKEN_BUCKET_BUDGET_PACER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pacer check failed");

// Next-cycle implication, disabled during reset.
`define TBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pacer check failed");

// Next-cycle implication that also holds across reset.
`define TBP_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pacer check failed");

`endif

### sv/tbp_pkg.sv
// Package for the token bucket budget pacer: widths, codes, structs, helpers.
// No dependencies; used by every other file of the block but the macros header.
package tbp_pkg;

  localparam int unsigned WIN_W         = 48;
  localparam int unsigned CAP_W         = 40;
  localparam int unsigned RATE_W        = 32;
  localparam int unsigned PRICE_W       = 32;
  localparam int unsigned TOK_W         = 50;
  localparam int unsigned SPENT_W       = 48;
  localparam int unsigned CNT_W         = 40;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 48;
  localparam int unsigned NEED_W        = 42;
  localparam int unsigned DEF_TIME_BITS = 48;
  localparam int unsigned MILLI         = 1000;

  localparam logic ACT_CHECK  = 1'b0;
  localparam logic ACT_RECORD = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED    = 3'd0,
    ST_PACING_OFF = 3'd1,
    ST_OUTSIDE    = 3'd2,
    ST_NO_TOKENS  = 3'd3,
    ST_RECORDED   = 3'd4
  } tbp_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PACING_ENABLE = 3'd0,
    REG_WINDOW_START  = 3'd1,
    REG_WINDOW_END    = 3'd2,
    REG_BUDGET_CAP    = 3'd3,
    REG_REFILL_RATE   = 3'd4
  } tbp_reg_t;

  typedef struct packed {
    logic               pacing_enable;
    logic [WIN_W-1:0]   window_start;
    logic [WIN_W-1:0]   window_end;
    logic [TOK_W-1:0]   cap_milli;
    logic [RATE_W-1:0]  refill_rate;
  } tbp_cfg_t;

  typedef struct packed {
    logic               recalc;
    logic               action;
    logic               in_window;
    logic [PRICE_W-1:0] price;
    logic [NEED_W-1:0]  need;
  } tbp_item_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

### sv/tbp_ifs.sv
// Channel interfaces of the pacer: input items, results and register writes.
// Depends on tbp_pkg for the field widths.
interface tbp_in_if;
  import tbp_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [WIN_W-1:0]   now_ms;
  logic [PRICE_W-1:0] price;
  modport source (output valid, action, now_ms, price, input ready);
  modport sink (input valid, action, now_ms, price, output ready);
endinterface

interface tbp_out_if;
  import tbp_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                allowed;
  logic [TOK_W-1:0]    tokens_left;
  logic [SPENT_W-1:0]  spent_total;
  logic [CNT_W-1:0]    impressions_total;
  logic [CNT_W-1:0]    checks_total;
  logic [CNT_W-1:0]    allows_total;
  logic [CNT_W-1:0]    denies_total;
  modport source (output valid, status, allowed, tokens_left, spent_total,
                  impressions_total, checks_total, allows_total, denies_total,
                  input ready);
  modport sink (input valid, status, allowed, tokens_left, spent_total,
                impressions_total, checks_total, allows_total, denies_total,
                output ready);
endinterface

interface tbp_cfg_if;
  import tbp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/tbp_cfg_regs.sv
// Configuration registers of the pacer; the budget is stored pre-scaled to thousandths.
// Depends on tbp_pkg and the tbp_cfg_if interface.
module tbp_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  tbp_cfg_if.sink           cfg_chan,
  output tbp_pkg::tbp_cfg_t cfg,
  output logic              rate_wr
);
  import tbp_pkg::*;

  logic              pacing_r;
  logic [WIN_W-1:0]  wstart_r;
  logic [WIN_W-1:0]  wend_r;
  logic [TOK_W-1:0]  cap_r;
  logic [RATE_W-1:0] rate_r;
  tbp_reg_t          idx;

  assign cfg_chan.ready = 1'b1;
  assign idx = tbp_reg_t'(cfg_chan.index);
  assign rate_wr = cfg_chan.valid && (idx == REG_REFILL_RATE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pacing_r <= 1'b0;
      wstart_r <= '0;
      wend_r   <= '1;
      cap_r    <= '0;
      rate_r   <= '0;
    end else if (cfg_chan.valid) begin
      case (idx)
        REG_PACING_ENABLE: pacing_r <= cfg_chan.data[0];
        REG_WINDOW_START:  wstart_r <= cfg_chan.data[WIN_W-1:0];
        REG_WINDOW_END:    wend_r   <= cfg_chan.data[WIN_W-1:0];
        REG_BUDGET_CAP:    cap_r    <= TOK_W'(cfg_chan.data[CAP_W-1:0]) * TOK_W'(MILLI);
        REG_REFILL_RATE:   rate_r   <= cfg_chan.data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.pacing_enable = pacing_r;
  assign cfg.window_start  = wstart_r;
  assign cfg.window_end    = wend_r;
  assign cfg.cap_milli     = cap_r;
  assign cfg.refill_rate   = rate_r;

endmodule

### sv/tbp_front.sv
// Front pipeline of the pacer: rate times time partial products, price scaling, window test.
// Depends on tbp_pkg and the tbp_in_if interface.
module tbp_front #(
  parameter int unsigned TIME_BITS = tbp_pkg::DEF_TIME_BITS,
  localparam int unsigned TW = (TIME_BITS < tbp_pkg::WIN_W) ? TIME_BITS : tbp_pkg::WIN_W,
  localparam int unsigned PW = TW + tbp_pkg::RATE_W
) (
  input  logic               clk,
  input  logic               rst_n,
  tbp_in_if.sink             in_chan,
  input  tbp_pkg::tbp_cfg_t  cfg,
  input  logic               rate_wr,
  input  logic [TW-1:0]      last_time,
  input  logic               core_take,
  output logic               s2_v,
  output tbp_pkg::tbp_item_t s2_item,
  output logic [TW-1:0]      s2_now,
  output logic [PW-1:0]      s2_pnow
);
  import tbp_pkg::*;

  localparam int unsigned LO_W = (TW + 1) / 2;
  localparam int unsigned HI_W = TW - LO_W;

  logic                   dirty_r;
  logic                   dirty_nxt;
  logic                   s1_v_r;
  tbp_item_t              s1_item_r;
  logic [TW-1:0]          s1_now_r;
  logic [LO_W+RATE_W-1:0] s1_lo_r;
  logic [HI_W+RATE_W-1:0] s1_hi_r;
  logic                   s2_v_r;
  tbp_item_t              s2_item_r;
  logic [TW-1:0]          s2_now_r;
  logic [PW-1:0]          s2_pnow_r;

  logic                   s2_free;
  logic                   s1_free;
  logic                   inject;
  logic                   take_in;
  logic                   load1;
  logic [TW-1:0]          src_now;
  logic [WIN_W-1:0]       wnow;
  tbp_item_t              new_item;

  assign s2_free = !s2_v_r || core_take;
  assign s1_free = !s1_v_r || s2_free;
  assign in_chan.ready = s1_free && !dirty_r;
  assign inject  = dirty_r && s1_free;
  assign take_in = in_chan.valid && in_chan.ready;
  assign load1   = take_in || inject;
  assign dirty_nxt = rate_wr ? 1'b1 : (inject ? 1'b0 : dirty_r);

  assign src_now = inject ? last_time : in_chan.now_ms[TW-1:0];
  assign wnow    = WIN_W'(src_now);

  always_comb begin
    new_item.recalc    = inject;
    new_item.action    = inject ? ACT_CHECK : in_chan.action;
    new_item.in_window = (wnow >= cfg.window_start) && (wnow <= cfg.window_end);
    new_item.price     = in_chan.price;
    new_item.need      = NEED_W'(in_chan.price) * NEED_W'(MILLI);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      dirty_r <= dirty_nxt;
      if (s1_free) begin
        s1_v_r <= load1;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && load1) begin
      s1_item_r <= new_item;
      s1_now_r  <= src_now;
      s1_lo_r   <= (LO_W+RATE_W)'(src_now[LO_W-1:0]) * (LO_W+RATE_W)'(cfg.refill_rate);
      s1_hi_r   <= (HI_W+RATE_W)'(src_now[TW-1:LO_W]) * (HI_W+RATE_W)'(cfg.refill_rate);
    end
    if (s2_free && s1_v_r) begin
      s2_item_r <= s1_item_r;
      s2_now_r  <= s1_now_r;
      s2_pnow_r <= (PW'(s1_hi_r) << LO_W) + PW'(s1_lo_r);
    end
  end

  assign s2_v    = s2_v_r;
  assign s2_item = s2_item_r;
  assign s2_now  = s2_now_r;
  assign s2_pnow = s2_pnow_r;

endmodule

### sv/tbp_core.sv
// Pacer state and result register: bucket refill, grant decision and saturating counters.
// Depends on tbp_pkg and the tbp_out_if interface.
module tbp_core #(
  parameter int unsigned TIME_BITS = tbp_pkg::DEF_TIME_BITS,
  localparam int unsigned TW = (TIME_BITS < tbp_pkg::WIN_W) ? TIME_BITS : tbp_pkg::WIN_W,
  localparam int unsigned PW = TW + tbp_pkg::RATE_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tbp_pkg::tbp_cfg_t  cfg,
  input  logic               s2_v,
  input  tbp_pkg::tbp_item_t s2_item,
  input  logic [TW-1:0]      s2_now,
  input  logic [PW-1:0]      s2_pnow,
  output logic               core_take,
  output logic [TW-1:0]      last_time,
  tbp_out_if.source          out_chan
);
  import tbp_pkg::*;

  logic               started_r, started_nxt;
  logic [TOK_W-1:0]   tok_r, tok_nxt;
  logic [TW-1:0]      last_r, last_nxt;
  logic [PW-1:0]      plast_r, plast_nxt;
  logic [SPENT_W-1:0] spent_r, spent_nxt;
  logic [CNT_W-1:0]   imp_r, imp_nxt;
  logic [CNT_W-1:0]   chk_r, chk_nxt;
  logic [CNT_W-1:0]   alw_r, alw_nxt;
  logic [CNT_W-1:0]   dny_r, dny_nxt;

  logic               out_v_r;
  tbp_status_t        status_r, status_nxt;
  logic               allowed_r, allowed_nxt;
  logic [TOK_W-1:0]   out_tok_r;
  logic [SPENT_W-1:0] out_spent_r;
  logic [CNT_W-1:0]   out_imp_r, out_chk_r, out_alw_r, out_dny_r;

  logic               out_load;
  logic [SPENT_W:0]   spent_sum;
  logic [PW-1:0]      diff;
  logic [TOK_W:0]     tok_sum;
  logic [TOK_W-1:0]   tok_fill;

  assign core_take = s2_v && (s2_item.recalc || !out_v_r || out_chan.ready);
  assign out_load  = core_take && !s2_item.recalc;
  assign last_time = last_r;

  assign spent_sum = (SPENT_W+1)'(spent_r) + (SPENT_W+1)'(s2_item.price);
  assign diff      = s2_pnow - plast_r;
  assign tok_sum   = (TOK_W+1)'(tok_r) + (TOK_W+1)'(diff[TOK_W-1:0]);

  always_comb begin
    started_nxt = started_r;
    tok_nxt     = tok_r;
    last_nxt    = last_r;
    plast_nxt   = plast_r;
    spent_nxt   = spent_r;
    imp_nxt     = imp_r;
    chk_nxt     = chk_r;
    alw_nxt     = alw_r;
    dny_nxt     = dny_r;
    status_nxt  = ST_PACING_OFF;
    allowed_nxt = 1'b0;
    tok_fill    = tok_r;
    if (s2_item.recalc) begin
      plast_nxt = s2_pnow;
    end else if (s2_item.action == ACT_RECORD) begin
      spent_nxt  = (spent_sum[SPENT_W] || (&spent_sum[SPENT_W-1:0])) ? '1
                                                                  : spent_sum[SPENT_W-1:0];
      imp_nxt    = sat_inc(imp_r);
      status_nxt = ST_RECORDED;
    end else if (!cfg.pacing_enable) begin
      status_nxt  = ST_PACING_OFF;
      allowed_nxt = 1'b1;
    end else begin
      chk_nxt = sat_inc(chk_r);
      if (!s2_item.in_window) begin
        status_nxt = ST_OUTSIDE;
      end else begin
        if (!started_r) begin
          started_nxt = 1'b1;
          tok_fill    = cfg.cap_milli;
          last_nxt    = s2_now;
          plast_nxt   = s2_pnow;
        end else if (s2_now > last_r) begin
          tok_fill  = ((|diff[PW-1:TOK_W]) || (tok_sum > (TOK_W+1)'(cfg.cap_milli)))
                      ? cfg.cap_milli : tok_sum[TOK_W-1:0];
          last_nxt  = s2_now;
          plast_nxt = s2_pnow;
        end
        if (tok_fill >= TOK_W'(s2_item.need)) begin
          tok_nxt     = tok_fill - TOK_W'(s2_item.need);
          alw_nxt     = sat_inc(alw_r);
          status_nxt  = ST_GRANTED;
          allowed_nxt = 1'b1;
        end else begin
          tok_nxt    = tok_fill;
          dny_nxt    = sat_inc(dny_r);
          status_nxt = ST_NO_TOKENS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      tok_r     <= '0;
      last_r    <= '0;
      plast_r   <= '0;
      spent_r   <= '0;
      imp_r     <= '0;
      chk_r     <= '0;
      alw_r     <= '0;
      dny_r     <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (core_take) begin
        started_r <= started_nxt;
        tok_r     <= tok_nxt;
        last_r    <= last_nxt;
        plast_r   <= plast_nxt;
        spent_r   <= spent_nxt;
        imp_r     <= imp_nxt;
        chk_r     <= chk_nxt;
        alw_r     <= alw_nxt;
        dny_r     <= dny_nxt;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r    <= status_nxt;
      allowed_r   <= allowed_nxt;
      out_tok_r   <= tok_nxt;
      out_spent_r <= spent_nxt;
      out_imp_r   <= imp_nxt;
      out_chk_r   <= chk_nxt;
      out_alw_r   <= alw_nxt;
      out_dny_r   <= dny_nxt;
    end
  end

  assign out_chan.valid             = out_v_r;
  assign out_chan.status            = status_r;
  assign out_chan.allowed           = allowed_r;
  assign out_chan.tokens_left       = out_tok_r;
  assign out_chan.spent_total       = out_spent_r;
  assign out_chan.impressions_total = out_imp_r;
  assign out_chan.checks_total      = out_chk_r;
  assign out_chan.allows_total      = out_alw_r;
  assign out_chan.denies_total      = out_dny_r;

endmodule

### sv/token_bucket_budget_pacer_unit.sv
// Top level of the token bucket budget pacer for one campaign.
// Depends on tbp_pkg, tbp_ifs, tbp_cfg_regs, tbp_front and tbp_core.
//
// Channels: in_chan takes check or record items, out_chan returns one result per
// item in order, cfg_chan writes registers and is always ready.
// Throughput is one item per cycle while out_chan does not stall and no
// refill_rate write is pending. Behind each item transfer come one register
// for the rate times time partial products, one for their sum, then the
// bucket update into the result register.
// The refill is the difference of two stored rate times time products, so a
// write to refill_rate holds in_chan.ready low while a recalc item for the
// last refill time is injected to recompute that product at the new rate.
// Reset clears the bucket, the counters and all valid flags and loads the
// register defaults. When out_chan stalls, the result is held and up to two more
// items are taken before in_chan.ready drops.
module token_bucket_budget_pacer_unit #(
  parameter int unsigned TIME_BITS = tbp_pkg::DEF_TIME_BITS,
  localparam int unsigned TW = (TIME_BITS < tbp_pkg::WIN_W) ? TIME_BITS : tbp_pkg::WIN_W,
  localparam int unsigned PW = TW + tbp_pkg::RATE_W
) (
  input  logic      clk,
  input  logic      rst_n,
  tbp_in_if.sink    in_chan,
  tbp_out_if.source out_chan,
  tbp_cfg_if.sink   cfg_chan
);
  import tbp_pkg::*;

  tbp_cfg_t      cfg;
  logic          rate_wr;
  logic [TW-1:0] last_time;
  logic          core_take;
  logic          s2_v;
  tbp_item_t     s2_item;
  logic [TW-1:0] s2_now;
  logic [PW-1:0] s2_pnow;

  tbp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg),
    .rate_wr  (rate_wr)
  );

  tbp_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg),
    .rate_wr   (rate_wr),
    .last_time (last_time),
    .core_take (core_take),
    .s2_v      (s2_v),
    .s2_item   (s2_item),
    .s2_now    (s2_now),
    .s2_pnow   (s2_pnow)
  );

  tbp_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s2_v      (s2_v),
    .s2_item   (s2_item),
    .s2_now    (s2_now),
    .s2_pnow   (s2_pnow),
    .core_take (core_take),
    .last_time (last_time),
    .out_chan  (out_chan)
  );

endmodule

### sv/tbp_checker.sv
// Port-level checker for the pacer result channel, bound to the top level.
// Depends on tbp_pkg and token_bucket_budget_pacer_unit_macros.svh.
`include "token_bucket_budget_pacer_unit_macros.svh"

module tbp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tbp_pkg::STATUS_W-1:0] status,
  input logic                         allowed,
  input logic [tbp_pkg::TOK_W-1:0]    tokens_left,
  input logic [tbp_pkg::CNT_W-1:0]    checks_total,
  input logic [tbp_pkg::CNT_W-1:0]    allows_total,
  input logic [tbp_pkg::CNT_W-1:0]    denies_total
);
  import tbp_pkg::*;

  `TBP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid)
  `TBP_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(tokens_left) && $stable(status))
  `TBP_ASSERT_SAME(a_allowed_code, clk, rst_n, out_valid, allowed == ((status == ST_GRANTED) || (status == ST_PACING_OFF)))
  `TBP_ASSERT_SAME(a_counts_order, clk, rst_n, out_valid, (allows_total <= checks_total) && (denies_total <= checks_total))

endmodule

bind token_bucket_budget_pacer_unit tbp_checker u_tbp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .status       (out_chan.status),
  .allowed      (out_chan.allowed),
  .tokens_left  (out_chan.tokens_left),
  .checks_total (out_chan.checks_total),
  .allows_total (out_chan.allows_total),
  .denies_total (out_chan.denies_total)
);
